// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the converter modules.
// All checks sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold in the same cycle.
`define RTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define RTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, constants and helpers of the raster to tile converter.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // Image geometry
  localparam int MaxWidthTiles  = 64;
  localparam int MaxHeightTiles = 1024;
  localparam int PixW           = 4;
  localparam int PixPerWord     = 8;
  localparam int WordW          = PixW * PixPerWord;
  localparam int PartW          = PixW * (PixPerWord - 1);
  localparam int TileRows       = 8;
  localparam int StoreRows      = TileRows - 1;

  // Field and counter widths
  localparam int ByteW   = 8;
  localparam int WidthW  = 7;
  localparam int HeightW = 11;
  localparam int ColW    = $clog2(MaxWidthTiles);
  localparam int RowW    = $clog2(TileRows);
  localparam int PixCntW = $clog2(PixPerWord);
  localparam int BandW   = $clog2(MaxHeightTiles);
  localparam int TileW   = 16;

  // Line store
  localparam int MemDepth = StoreRows * MaxWidthTiles;
  localparam int AddrW    = $clog2(MemDepth);

  // Command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = HeightW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidthTiles  = 2'd0,
    CfgHeightTiles = 2'd1,
    CfgPackedInput = 2'd2
  } cfg_idx_t;

  // One finished row word and what to do with it
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             emit;
    logic             last;
    logic [TileW-1:0] tile;
  } word_cmd_t;

  // Width in tiles, clamped to 1..MaxWidthTiles
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    r = w;
    if (w == '0) r = WidthW'(1);
    else if (int'(w) > MaxWidthTiles) r = WidthW'(MaxWidthTiles);
    return r;
  endfunction

  // Height in tiles, clamped to 1..MaxHeightTiles
  function automatic logic [HeightW-1:0] eff_height(input logic [HeightW-1:0] h);
    logic [HeightW-1:0] r;
    r = h;
    if (h == '0) r = HeightW'(1);
    else if (int'(h) > MaxHeightTiles) r = HeightW'(MaxHeightTiles);
    return r;
  endfunction

  // Line store address of a row and tile column
  function automatic logic [AddrW-1:0] mem_addr(input logic [RowW-1:0] row,
                                                input logic [ColW-1:0] col);
    return AddrW'(int'(row) * MaxWidthTiles + int'(col));
  endfunction

  // Queue pointer advance with wrap
  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    r = p + QPtrW'(1);
    if (int'(p) == QDepth - 1) r = '0;
    return r;
  endfunction

endpackage

// ===== rtl/core/rtt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_in_if
// Pixel byte request channel: valid, ready and one raster byte.
// ----------------------------------------------------------------------------
interface rtt_in_if;
  logic                      valid;
  logic                      ready;
  logic [rtt_pkg::ByteW-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

// ===== rtl/core/rtt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_out_if
// Tile row request channel: valid, ready and one tile row word with its tags.
// ----------------------------------------------------------------------------
interface rtt_out_if;
  logic                      valid;
  logic                      ready;
  logic [rtt_pkg::WordW-1:0] row_word;
  logic [rtt_pkg::RowW-1:0]  row_of_tile;
  logic                      last_row_of_tile;
  logic [rtt_pkg::TileW-1:0] tile_number;
  logic                      last_tile_of_image;

  modport source (output valid, output row_word, output row_of_tile,
                  output last_row_of_tile, output tile_number,
                  output last_tile_of_image, input ready);
  modport sink   (input valid, input row_word, input row_of_tile,
                  input last_row_of_tile, input tile_number,
                  input last_tile_of_image, output ready);
endinterface

// ===== rtl/core/rtt_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rtt_front
// Holds configuration, packs pixels into row words and classifies each
// finished word as a line store write or a tile emit.
// ----------------------------------------------------------------------------
module rtt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rtt_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [rtt_pkg::CfgDataW-1:0] cfg_wdata,
  rtt_in_if.sink                       in_stream,
  output logic                         push,
  output rtt_pkg::word_cmd_t           push_cmd,
  input  logic                         q_full
);
  import rtt_pkg::*;

  logic [WidthW-1:0]  width_r;
  logic [HeightW-1:0] height_r;
  logic               packed_r;

  logic [PartW-1:0]   word_r, word_nxt;
  logic [PixCntW-1:0] pix_r, pix_nxt;
  logic [ColW-1:0]    col_r, col_nxt;
  logic [RowW-1:0]    row_r, row_nxt;
  logic [BandW-1:0]   band_r, band_nxt;
  logic [TileW-1:0]   tile_r, tile_nxt;

  logic               accept;
  logic               done;
  logic [WordW-1:0]   done_word;
  logic [PixW-1:0]    hi_nib, lo_nib;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               row_end;
  logic               emit;
  logic               last;

  assign in_stream.ready = !q_full;
  assign accept = in_stream.valid && in_stream.ready;
  assign hi_nib = in_stream.pixel_byte[ByteW-1:PixW];
  assign lo_nib = in_stream.pixel_byte[PixW-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WidthW'(1);
      height_r <= HeightW'(1);
      packed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CfgWidthTiles:  width_r  <= cfg_wdata[WidthW-1:0];
        CfgHeightTiles: height_r <= cfg_wdata[HeightW-1:0];
        CfgPackedInput: packed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Shift one or two nibbles into the partial word
  always_comb begin
    done      = 1'b0;
    done_word = '0;
    word_nxt  = word_r;
    pix_nxt   = pix_r;
    if (packed_r) begin
      if (pix_r == PixCntW'(PixPerWord - 1)) begin
        // first nibble closes the word, second opens the next one
        done      = 1'b1;
        done_word = {word_r, hi_nib};
        word_nxt  = PartW'(lo_nib);
        pix_nxt   = PixCntW'(1);
      end else if (pix_r == PixCntW'(PixPerWord - 2)) begin
        done      = 1'b1;
        done_word = {word_r[PartW-PixW-1:0], hi_nib, lo_nib};
        word_nxt  = '0;
        pix_nxt   = '0;
      end else begin
        word_nxt  = {word_r[PartW-2*PixW-1:0], hi_nib, lo_nib};
        pix_nxt   = pix_r + PixCntW'(2);
      end
    end else begin
      if (pix_r == PixCntW'(PixPerWord - 1)) begin
        done      = 1'b1;
        done_word = {word_r, lo_nib};
        word_nxt  = '0;
        pix_nxt   = '0;
      end else begin
        word_nxt  = {word_r[PartW-PixW-1:0], lo_nib};
        pix_nxt   = pix_r + PixCntW'(1);
      end
    end
  end

  // Classify the finished word and advance the position counters
  always_comb begin
    w_eff    = eff_width(width_r);
    h_eff    = eff_height(height_r);
    row_end  = (WidthW'(col_r) + WidthW'(1)) >= w_eff;
    emit     = (row_r == RowW'(StoreRows));
    last     = emit && row_end && (band_r == BandW'(h_eff - HeightW'(1)));
    col_nxt  = col_r;
    row_nxt  = row_r;
    band_nxt = band_r;
    tile_nxt = tile_r;
    if (emit) begin
      tile_nxt = tile_r + TileW'(1);
    end
    if (last) begin
      col_nxt  = '0;
      row_nxt  = '0;
      band_nxt = '0;
      tile_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      if (emit) begin
        row_nxt  = '0;
        band_nxt = band_r + BandW'(1);
      end else begin
        row_nxt = row_r + RowW'(1);
      end
    end else begin
      col_nxt = col_r + ColW'(1);
    end
  end

  assign push          = accept && done;
  assign push_cmd.word = done_word;
  assign push_cmd.col  = col_r;
  assign push_cmd.row  = row_r;
  assign push_cmd.emit = emit;
  assign push_cmd.last = last;
  assign push_cmd.tile = tile_r;

  // Hold packing and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      pix_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      band_r <= '0;
      tile_r <= '0;
    end else if (accept) begin
      word_r <= word_nxt;
      pix_r  <= pix_nxt;
      if (done) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        band_r <= band_nxt;
        tile_r <= tile_nxt;
      end
    end
  end

  `RTT_ASSERT_NXT(a_end_of_image_restart, push && push_cmd.last,
                  band_r == '0 && tile_r == '0 && col_r == '0 && row_r == '0,
                  "position counters not cleared after the final tile")
  `RTT_ASSERT_IMP(a_emit_only_on_last_row, push && push_cmd.emit,
                  push_cmd.row == RowW'(StoreRows),
                  "tile emit requested before the last band row")

endmodule

// ===== rtl/core/rtt_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rtt_fifo
// Short command queue that decouples the packing front from the emit back.
// ----------------------------------------------------------------------------
module rtt_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rtt_pkg::word_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output rtt_pkg::word_cmd_t pop_cmd,
  output logic               valid
);
  import rtt_pkg::*;

  word_cmd_t        q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == QCntW'(QDepth));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = q_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= next_ptr(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= next_ptr(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + QCntW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCntW'(1);
    end
  end

  `RTT_ASSERT(a_cnt_bound, cnt_r <= QCntW'(QDepth), "queue count beyond depth")
  `RTT_ASSERT_NXT(a_cnt_inc, do_push && !do_pop, cnt_r == $past(cnt_r) + QCntW'(1),
                  "queue count did not grow on push")

endmodule

// ===== rtl/core/rtt_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rtt_back
// Carries out queued commands: writes rows 0..6 to the line store and, on an
// emit, streams the tile's eight row words through the output register.
// ----------------------------------------------------------------------------
module rtt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rtt_pkg::word_cmd_t q_cmd,
  output logic               q_pop,
  rtt_out_if.source          out_stream
);
  import rtt_pkg::*;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [RowW-1:0]  emit_row_r, emit_row_nxt;
  logic [ColW-1:0]  col_r;
  logic [WordW-1:0] word7_r;
  logic [TileW-1:0] tile_r;
  logic             last_r;

  logic [WordW-1:0] mem [MemDepth];
  logic [WordW-1:0] mem_q_r;

  logic             out_vld_r;
  logic [WordW-1:0] out_word_r;
  logic [RowW-1:0]  out_row_r;
  logic             out_last_row_r;
  logic [TileW-1:0] out_tile_r;
  logic             out_last_tile_r;

  logic             can_load;
  logic             load;
  logic             mem_we;
  logic             rd_en;
  logic [ColW-1:0]  rd_col;
  logic [AddrW-1:0] rd_addr;
  logic             final_row;

  assign can_load  = !out_vld_r || out_stream.ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign load      = (state_r == S_EMIT) && can_load;
  assign mem_we    = q_pop && !q_cmd.emit;
  assign final_row = (emit_row_r == RowW'(StoreRows));

  // Next state and the line store read address of the row to be loaded next
  always_comb begin
    state_nxt    = state_r;
    emit_row_nxt = emit_row_r;
    rd_col       = col_r;
    unique case (state_r)
      S_IDLE: begin
        rd_col = q_cmd.col;
        if (q_pop && q_cmd.emit) begin
          state_nxt    = S_EMIT;
          emit_row_nxt = '0;
        end
      end
      S_EMIT: begin
        if (load) begin
          emit_row_nxt = emit_row_r + RowW'(1);
          if (final_row) state_nxt = S_IDLE;
        end
      end
    endcase
    rd_en   = (state_nxt == S_EMIT) && (emit_row_nxt != RowW'(StoreRows));
    rd_addr = mem_addr(emit_row_nxt, rd_col);
  end

  // Line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr(q_cmd.row, q_cmd.col)] <= q_cmd.word;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Sequencer state, latched tile command and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      emit_row_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_row_r <= emit_row_nxt;
      if (q_pop && q_cmd.emit) begin
        col_r   <= q_cmd.col;
        word7_r <= q_cmd.word;
        tile_r  <= q_cmd.tile;
        last_r  <= q_cmd.last;
      end
      if (load) begin
        out_vld_r       <= 1'b1;
        out_word_r      <= final_row ? word7_r : mem_q_r;
        out_row_r       <= emit_row_r;
        out_last_row_r  <= final_row;
        out_tile_r      <= tile_r;
        out_last_tile_r <= last_r;
      end else if (out_stream.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_stream.valid              = out_vld_r;
  assign out_stream.row_word           = out_word_r;
  assign out_stream.row_of_tile        = out_row_r;
  assign out_stream.last_row_of_tile   = out_last_row_r;
  assign out_stream.tile_number        = out_tile_r;
  assign out_stream.last_tile_of_image = out_last_tile_r;

  `RTT_ASSERT_IMP(a_rows_in_order, state_r == S_EMIT && emit_row_r != '0,
                  out_tile_r == tile_r && out_row_r == emit_row_r - RowW'(1),
                  "tile rows leave out of order")
  `RTT_ASSERT_NXT(a_tile_done, load && final_row,
                  state_r == S_IDLE && out_vld_r && out_last_row_r,
                  "sequencer did not finish on the last tile row")

endmodule

// ===== rtl/core/raster_to_tile_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_to_tile_converter_unit
// Regroups a raster stream of 4-bit pixel indices into 8x8 tile row words.
// ----------------------------------------------------------------------------
// Usage:
//   Write width_tiles, height_tiles and packed_input on the cfg_ port while
//   the block is idle. Feed raster bytes on in_stream; each byte carries one
//   pixel (low nibble) or two pixels (high nibble first). Rows 0..6 of each
//   band go to the on-chip line store; on row 7 every completed tile column
//   yields eight 32-bit words on out_stream, top row first, tagged with the
//   tile row, tile number and end-of-tile / end-of-image marks.
//   The first word of a tile passes the command queue, the line store read
//   register and the output register. The input takes one byte per cycle
//   while the command queue has room; the back end writes store words only
//   between tiles; a tile gives one row word per cycle while out_stream is
//   ready (set by the single line store read port).
//   Reset (rst_n low, synchronous) restores the default configuration and
//   starts a new image; line store contents are not cleared.
//   When out_stream stalls, the output register holds its word, the queue
//   fills and in_stream.ready drops until words drain again.
// ----------------------------------------------------------------------------
module raster_to_tile_converter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rtt_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [rtt_pkg::CfgDataW-1:0] cfg_wdata,
  rtt_in_if.sink                       in_stream,
  rtt_out_if.source                    out_stream
);
  import rtt_pkg::*;

  logic      push;
  word_cmd_t push_cmd;
  logic      q_full;
  logic      q_pop;
  word_cmd_t q_cmd;
  logic      q_valid;

  // Pack and classify
  rtt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_stream (in_stream),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // Decouple front and back
  rtt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .valid    (q_valid)
  );

  // Store rows and emit tiles
  rtt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
